FILE: design/phist_pkg.sv
// ----------------------------------------------------------------------------
// Photon histogram package
// Shared constants and operation codes for the photon event pixel histogram.
// ----------------------------------------------------------------------------
package phist_pkg;

	// Default store size, in pixel columns and rows.
	localparam int DEF_MAX_COLUMNS = 256;
	localparam int DEF_MAX_ROWS    = 256;

	// Depths of the command queue and of the result queue.
	localparam int CMD_DEPTH = 4;
	localparam int OUT_DEPTH = 4;

	// Top byte that marks a packet header in the stream.
	localparam logic [7:0] HEADER_MARK = 8'hFF;

	// Size register reset value and register indexes.
	localparam logic [8:0] SIZE_RESET      = 9'd256;
	localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;

	// Field widths of the request and result items.
	localparam int WORD_W  = 64;
	localparam int COORD_W = 8;
	localparam int COUNT_W = 16;
	localparam int SIZE_W  = 9;
	localparam int EV_W    = 10;

	// Operations handed from the front part to the back part.
	typedef enum logic [1:0] {
		OP_INC      = 2'd0,
		OP_READ     = 2'd1,
		OP_READ_OOR = 2'd2
	} op_t;

	localparam int OP_W = 2;

endpackage

FILE: design/phist_ram.sv
// ----------------------------------------------------------------------------
// Photon histogram RAM
// Simple dual port memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module phist_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 65536
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// A read at the address being written returns the old contents.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: design/phist_fifo.sv
// ----------------------------------------------------------------------------
// Photon histogram queue
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module phist_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    cnt_q;
	logic             push_ok;
	logic             pop_ok;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign push_ok = push && !full;
	assign pop_ok  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push_ok) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop_ok) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push_ok && !pop_ok) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop_ok && !push_ok) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push_ok) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

FILE: design/phist_front.sv
// ----------------------------------------------------------------------------
// Photon histogram front end
// Holds the size registers, accepts requests and turns them into commands.
// ----------------------------------------------------------------------------
module phist_front
	import phist_pkg::*;
#(
	parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
	parameter int MAX_ROWS    = DEF_MAX_ROWS,
	parameter int AW          = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      wr_en,
	input  logic [1:0]                wr_index,
	input  logic [SIZE_W-1:0]         wr_data,
	input  logic                      push,
	output logic                      full,
	input  logic                      kind,
	input  logic [WORD_W-1:0]         stream_word,
	input  logic [COORD_W-1:0]        read_column,
	input  logic [COORD_W-1:0]        read_row,
	input  logic                      clearing,
	input  logic                      q_full,
	output logic                      q_push,
	output logic [OP_W+AW+2*COORD_W-1:0] q_data
);

	logic [SIZE_W-1:0] image_width_q;
	logic [SIZE_W-1:0] image_height_q;
	logic [EV_W-1:0]   ev_x;
	logic [EV_W-1:0]   ev_y;
	logic              is_header;
	logic              ev_hit;
	logic              rd_inside;
	logic              accept;
	op_t               op;
	logic [AW-1:0]     addr;

	// Size registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= SIZE_RESET;
			image_height_q <= SIZE_RESET;
		end else if (wr_en) begin
			case (wr_index)
				REG_IMAGE_WIDTH:  image_width_q  <= wr_data;
				REG_IMAGE_HEIGHT: image_height_q <= wr_data;
				default: ;
			endcase
		end
	end

	// Decode the event coordinates and check them against the sizes.
	assign ev_x      = stream_word[63:54];
	assign ev_y      = stream_word[53:44];
	assign is_header = (stream_word[63:56] == HEADER_MARK);
	assign ev_hit    = !is_header
		&& ({1'b0, ev_x} < 11'(MAX_COLUMNS)) && (ev_x < {1'b0, image_width_q})
		&& ({1'b0, ev_y} < 11'(MAX_ROWS))    && (ev_y < {1'b0, image_height_q});
	assign rd_inside = ({3'b000, read_column} < 11'(MAX_COLUMNS))
		&& ({3'b000, read_row} < 11'(MAX_ROWS));

	// Pick the operation and the store address.
	always_comb begin
		if (kind) begin
			op   = rd_inside ? OP_READ : OP_READ_OOR;
			addr = AW'(AW'(read_column) * AW'(MAX_ROWS) + AW'(read_row));
		end else begin
			op   = OP_INC;
			addr = AW'(AW'(ev_x) * AW'(MAX_ROWS) + AW'(ev_y));
		end
	end

	// Requests wait while the store is being cleared or the queue is full.
	assign full   = q_full || clearing;
	assign accept = push && !full;
	assign q_push = accept && (kind || ev_hit);
	assign q_data = {op, addr, read_column, read_row};

endmodule

FILE: design/phist_back.sv
// ----------------------------------------------------------------------------
// Photon histogram back end
// Clears the store after reset, then runs read-modify-write commands on it.
// ----------------------------------------------------------------------------
module phist_back
	import phist_pkg::*;
#(
	parameter int DEPTH = 65536,
	parameter int AW    = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_empty,
	input  logic [OP_W+AW+2*COORD_W-1:0]  q_data,
	output logic                          q_pop,
	output logic                          clearing,
	output logic                          ram_we,
	output logic [AW-1:0]                 ram_waddr,
	output logic [COUNT_W-1:0]            ram_wdata,
	output logic [AW-1:0]                 ram_raddr,
	input  logic [COUNT_W-1:0]            ram_rdata,
	input  logic                          out_taken,
	output logic                          out_push,
	output logic [COUNT_W+2*COORD_W-1:0]  out_data
);

	localparam int CRW = $clog2(OUT_DEPTH + 1);

	logic                clr_q;
	logic [AW-1:0]       clr_addr_q;
	logic [CRW-1:0]      credits_q;
	op_t                 hd_op;
	logic [AW-1:0]       hd_addr;
	logic [COORD_W-1:0]  hd_col;
	logic [COORD_W-1:0]  hd_row;
	logic                hd_is_read;
	logic                issue;
	logic                vld_s1;
	op_t                 op_s1;
	logic [AW-1:0]       addr_s1;
	logic [COORD_W-1:0]  col_s1;
	logic [COORD_W-1:0]  row_s1;
	logic                fwd_s1;
	logic [COUNT_W-1:0]  fwd_data_s1;
	logic [COUNT_W-1:0]  old_cnt;
	logic [COUNT_W-1:0]  new_cnt;
	logic                wr_s1;

	// Unpack the command at the head of the queue.
	assign hd_op      = op_t'(q_data[AW+2*COORD_W +: OP_W]);
	assign hd_addr    = q_data[2*COORD_W +: AW];
	assign hd_col     = q_data[COORD_W +: COORD_W];
	assign hd_row     = q_data[COORD_W-1:0];
	assign hd_is_read = (hd_op == OP_READ) || (hd_op == OP_READ_OOR);

	// A read command starts only with a result slot reserved for it.
	assign issue    = !clr_q && !q_empty && (!hd_is_read || (credits_q != '0));
	assign q_pop    = issue;
	assign clearing = clr_q;

	// Clearing sweep over the whole store after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == AW'(DEPTH - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	// Free result slots, less those reserved by reads in flight.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credits_q <= CRW'(OUT_DEPTH);
		end else begin
			credits_q <= credits_q - CRW'(issue && hd_is_read) + CRW'(out_taken);
		end
	end

	// Stage one: the store data arrives; the previous write is forwarded
	// when it hit the same address in the cycle of the read.
	assign old_cnt = fwd_s1 ? fwd_data_s1 : ram_rdata;
	assign new_cnt = (op_s1 == OP_INC) ? old_cnt + 1'b1 : '0;
	assign wr_s1   = vld_s1 && ((op_s1 == OP_INC) || (op_s1 == OP_READ));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			fwd_s1 <= 1'b0;
		end else begin
			vld_s1 <= issue;
			fwd_s1 <= wr_s1 && (addr_s1 == hd_addr);
		end
	end

	always_ff @(posedge clk) begin
		op_s1       <= hd_op;
		addr_s1     <= hd_addr;
		col_s1      <= hd_col;
		row_s1      <= hd_row;
		fwd_data_s1 <= new_cnt;
	end

	// Store ports.
	assign ram_raddr = hd_addr;
	assign ram_we    = clr_q || wr_s1;
	assign ram_waddr = clr_q ? clr_addr_q : addr_s1;
	assign ram_wdata = clr_q ? '0 : new_cnt;

	// Results of read commands.
	assign out_push = vld_s1 && ((op_s1 == OP_READ) || (op_s1 == OP_READ_OOR));
	assign out_data = {((op_s1 == OP_READ) ? old_cnt : COUNT_W'(0)), col_s1, row_s1};

endmodule

FILE: design/photon_event_pixel_histogram.sv
// A read request passes through the command queue, the store read and stage one,
// and is then written into the result queue, from which it can be popped.
// Throughput: one request per cycle while the result side keeps popping.
// Rate is set by the store's single read-modify-write stage and its one write port.
// After reset the store is cleared one pixel a cycle, with full held high;
// size registers reset to 256.
// ----------------------------------------------------------------------------
// Photon event pixel histogram
// Counts photon events per pixel and reads out and clears single pixels.
// ----------------------------------------------------------------------------
module photon_event_pixel_histogram
	import phist_pkg::*;
#(
	parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
	parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  logic [1:0]         wr_index,
	input  logic [SIZE_W-1:0]  wr_data,
	input  logic               push,
	output logic               full,
	input  logic               kind,
	input  logic [WORD_W-1:0]  stream_word,
	input  logic [COORD_W-1:0] read_column,
	input  logic [COORD_W-1:0] read_row,
	output logic               empty,
	input  logic               pop,
	output logic [COUNT_W-1:0] pixel_count,
	output logic [COORD_W-1:0] pixel_column,
	output logic [COORD_W-1:0] pixel_row
);

	localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int QW    = OP_W + AW + 2 * COORD_W;
	localparam int RW    = COUNT_W + 2 * COORD_W;

	logic               clearing;
	logic               q_push;
	logic [QW-1:0]      q_wdata;
	logic               q_full;
	logic               q_pop;
	logic [QW-1:0]      q_rdata;
	logic               q_empty;
	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [COUNT_W-1:0] ram_wdata;
	logic [AW-1:0]      ram_raddr;
	logic [COUNT_W-1:0] ram_rdata;
	logic               out_push;
	logic [RW-1:0]      out_wdata;
	logic               out_full;
	logic [RW-1:0]      out_rdata;
	logic               out_taken;

	// Front end: size registers and request decode.
	phist_front #(
		.MAX_COLUMNS(MAX_COLUMNS),
		.MAX_ROWS   (MAX_ROWS),
		.AW         (AW)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (wr_en),
		.wr_index   (wr_index),
		.wr_data    (wr_data),
		.push       (push),
		.full       (full),
		.kind       (kind),
		.stream_word(stream_word),
		.read_column(read_column),
		.read_row   (read_row),
		.clearing   (clearing),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_data     (q_wdata)
	);

	// Command queue between the two halves.
	phist_fifo #(
		.WIDTH(QW),
		.DEPTH(CMD_DEPTH)
	) u_cmd_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.wdata (q_wdata),
		.full  (q_full),
		.pop   (q_pop),
		.rdata (q_rdata),
		.empty (q_empty)
	);

	// Back end: clearing sweep and read-modify-write on the store.
	phist_back #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_data   (q_rdata),
		.q_pop    (q_pop),
		.clearing (clearing),
		.ram_we   (ram_we),
		.ram_waddr(ram_waddr),
		.ram_wdata(ram_wdata),
		.ram_raddr(ram_raddr),
		.ram_rdata(ram_rdata),
		.out_taken(out_taken),
		.out_push (out_push),
		.out_data (out_wdata)
	);

	// Pixel count store.
	phist_ram #(
		.WIDTH(COUNT_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Result queue.
	phist_fifo #(
		.WIDTH(RW),
		.DEPTH(OUT_DEPTH)
	) u_out_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (out_push),
		.wdata (out_wdata),
		.full  (out_full),
		.pop   (pop),
		.rdata (out_rdata),
		.empty (empty)
	);

	assign out_taken    = pop && !empty;
	assign pixel_count  = out_rdata[RW-1 -: COUNT_W];
	assign pixel_column = out_rdata[COORD_W +: COORD_W];
	assign pixel_row    = out_rdata[COORD_W-1:0];

`ifndef SYNTH
	// The slot reservation keeps the result queue from overflowing.
	a_out_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(out_push && out_full))
		else $error("result pushed into a full result queue");

	// No command leaves the queue while the store is being cleared.
	a_no_issue_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !q_pop)
		else $error("command issued during the clearing sweep");

	// The clearing sweep runs once, right after reset.
	a_clear_once: assert property (@(posedge clk) disable iff (!arst_n)
		!$rose(clearing))
		else $error("clearing restarted outside reset");
`endif

endmodule
